// ----- rtl/chacha_pkg.sv -----
// Shared types, constants and round functions for the ChaCha20 stream XOR block.
package chacha_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;

    localparam int CHUNK_W   = 64;
    localparam int COUNT_W   = 4;
    localparam int TDATA_W   = 72;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SALT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd5;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic round;
        logic diag;
        logic feed;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic out_free;
    } ctrl_sts_t;

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic quad_t quarter(quad_t q);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        quad_t r;
        a = q.a;
        b = q.b;
        c = q.c;
        d = q.d;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

endpackage

// ----- rtl/chacha_ctrl.sv -----
// Sequencer for the ChaCha20 stream XOR block: item intake, round count, output request.
module chacha_ctrl #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  chacha_pkg::ctrl_sts_t sts,
    output chacha_pkg::ctrl_cmd_t cmd
);

    localparam int NUM_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int STEP_W     = $clog2(NUM_ROUNDS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_ROUNDS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FEED  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.diag    = step_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.pos_zero ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (step_reg == LAST_STEP) begin
                    step_next  = '0;
                    state_next = ST_FEED;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FEED: begin
                cmd.feed   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/chacha_core.sv -----
// Datapath: key/nonce registers, round state, keystream buffer and output register.
module chacha_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  chacha_pkg::ctrl_cmd_t                 cmd,
    output chacha_pkg::ctrl_sts_t                 sts,
    input  logic                                  cfg_valid,
    input  logic [chacha_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [chacha_pkg::CHUNK_W-1:0]        s_chunk,
    input  logic [chacha_pkg::COUNT_W-1:0]        s_count,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [chacha_pkg::CHUNK_W-1:0]        m_chunk,
    output logic [chacha_pkg::COUNT_W-1:0]        m_count,
    output logic                                  m_last
);

    logic [63:0]                       key_reg [4];
    logic [31:0]                       salt_reg;
    logic [63:0]                       nonce_reg;
    logic [31:0]                       counter_reg;
    logic [2:0]                        pos_reg;
    chacha_pkg::word_t                 ws_reg [16];
    logic [63:0]                       ks_reg [8];
    logic [chacha_pkg::CHUNK_W-1:0]    chunk_reg;
    logic [chacha_pkg::COUNT_W-1:0]    cnt_reg;
    logic                              last_reg;
    logic                              m_valid_reg;
    logic [chacha_pkg::CHUNK_W-1:0]    m_chunk_reg;
    logic [chacha_pkg::COUNT_W-1:0]    m_count_reg;
    logic                              m_last_reg;

    chacha_pkg::word_t                 init_w  [16];
    chacha_pkg::word_t                 round_w [16];
    chacha_pkg::quad_t                 qr_in   [4];
    chacha_pkg::quad_t                 qr_out  [4];
    logic [chacha_pkg::CHUNK_W-1:0]    mask;
    logic [chacha_pkg::COUNT_W-1:0]    cnt_clamp;

    always_comb begin
        init_w[0] = chacha_pkg::SIGMA_0;
        init_w[1] = chacha_pkg::SIGMA_1;
        init_w[2] = chacha_pkg::SIGMA_2;
        init_w[3] = chacha_pkg::SIGMA_3;
        for (int k = 0; k < 4; k++) begin
            init_w[4 + 2 * k] = key_reg[k][31:0];
            init_w[5 + 2 * k] = key_reg[k][63:32];
        end
        init_w[12] = counter_reg;
        init_w[13] = salt_reg;
        init_w[14] = nonce_reg[31:0];
        init_w[15] = nonce_reg[63:32];
    end

    // Column round on even steps, diagonal round on odd steps.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (!cmd.diag) begin
                qr_in[i] = {ws_reg[i], ws_reg[4 + i], ws_reg[8 + i], ws_reg[12 + i]};
            end else begin
                qr_in[i] = {ws_reg[i], ws_reg[4 + ((i + 1) & 3)],
                            ws_reg[8 + ((i + 2) & 3)], ws_reg[12 + ((i + 3) & 3)]};
            end
            qr_out[i] = chacha_pkg::quarter(qr_in[i]);
        end
        for (int j = 0; j < 16; j++) begin
            round_w[j] = ws_reg[j];
        end
        for (int i = 0; i < 4; i++) begin
            round_w[i] = qr_out[i].a;
            if (!cmd.diag) begin
                round_w[4 + i]  = qr_out[i].b;
                round_w[8 + i]  = qr_out[i].c;
                round_w[12 + i] = qr_out[i].d;
            end else begin
                round_w[4 + ((i + 1) & 3)]  = qr_out[i].b;
                round_w[8 + ((i + 2) & 3)]  = qr_out[i].c;
                round_w[12 + ((i + 3) & 3)] = qr_out[i].d;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            mask[8 * j +: 8] = (cnt_reg > chacha_pkg::COUNT_W'(j)) ? 8'hff : 8'h00;
        end
    end

    assign cnt_clamp = s_count[3] ? chacha_pkg::COUNT_W'(8) : s_count;

    // config and sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                key_reg[k] <= '0;
            end
            salt_reg    <= '0;
            nonce_reg   <= '0;
            counter_reg <= 32'd1;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    chacha_pkg::REG_KEY0:  key_reg[0] <= cfg_data;
                    chacha_pkg::REG_KEY1:  key_reg[1] <= cfg_data;
                    chacha_pkg::REG_KEY2:  key_reg[2] <= cfg_data;
                    chacha_pkg::REG_KEY3:  key_reg[3] <= cfg_data;
                    chacha_pkg::REG_SALT:  salt_reg   <= cfg_data[31:0];
                    chacha_pkg::REG_NONCE: nonce_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.feed) begin
                counter_reg <= counter_reg + 32'd1;
            end
            if (cmd.emit) begin
                if (last_reg) begin
                    pos_reg     <= '0;
                    counter_reg <= 32'd1;
                end else begin
                    pos_reg <= pos_reg + 3'd1;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            chunk_reg <= s_chunk;
            cnt_reg   <= cnt_clamp;
            last_reg  <= s_last;
        end
        if (cmd.load) begin
            for (int j = 0; j < 16; j++) begin
                ws_reg[j] <= init_w[j];
            end
        end else if (cmd.round) begin
            for (int j = 0; j < 16; j++) begin
                ws_reg[j] <= round_w[j];
            end
        end
        if (cmd.feed) begin
            for (int j = 0; j < 8; j++) begin
                ks_reg[j] <= {ws_reg[2 * j + 1] + init_w[2 * j + 1],
                              ws_reg[2 * j] + init_w[2 * j]};
            end
        end
        if (cmd.emit) begin
            m_chunk_reg <= (chunk_reg ^ ks_reg[pos_reg]) & mask;
            m_count_reg <= cnt_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign sts.pos_zero = (pos_reg == 3'd0);
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_chunk = m_chunk_reg;
    assign m_count = m_count_reg;
    assign m_last  = m_last_reg;

endmodule

// ----- rtl/chacha20_stream_xor.sv -----
// ChaCha20 stream XOR, 64-bit chunks. An item whose keystream block exists goes from capture
// straight to emit; one that opens a new block first runs load, the rounds (one column or
// diagonal round per cycle in the shared round unit) and feed-forward. Emit waits for a free
// output register and registers the result there; a new item is taken only when idle.
// aresetn (synchronous, active low) clears keys, salt, IV, counter to 1, position to 0.
module chacha20_stream_xor #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [63:0] in_chunk, [67:64] byte_count, [71:68] zero
    input  logic [chacha_pkg::TDATA_W-1:0]        s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [63:0] out_chunk, [67:64] out_count, [71:68] zero
    output logic [chacha_pkg::TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [chacha_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]     cfg_data
);

    chacha_pkg::ctrl_cmd_t              cmd;
    chacha_pkg::ctrl_sts_t              sts;
    logic [chacha_pkg::CHUNK_W-1:0]     m_chunk;
    logic [chacha_pkg::COUNT_W-1:0]     m_count;

    assign cfg_ready = 1'b1;

    chacha_ctrl #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    chacha_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_chunk   (s_tdata[63:0]),
        .s_count   (s_tdata[67:64]),
        .s_last    (s_tlast),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_chunk   (m_chunk),
        .m_count   (m_count),
        .m_last    (m_tlast)
    );

    assign m_tdata = {4'b0000, m_count, m_chunk};

endmodule
